/* sv/pbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the PackBits bi-level image decoder.
// No dependencies; imported by every module of the block.
package pbd_pkg;

	localparam logic [15:0] LIMIT_RESET  = 16'd51840;
	localparam logic [9:0]  HEADER_LEN   = 10'd512;
	localparam logic [9:0]  WRAP_HDR_LEN = 10'd640;
	localparam logic [9:0]  WRAP_POS_A   = 10'd74;
	localparam logic [9:0]  WRAP_POS_B   = 10'd82;
	localparam logic [7:0]  WRAP_LEN_LIM = 8'd64;
	localparam logic [7:0]  NOOP_COUNT   = 8'd128;
	localparam logic [8:0]  RUN_BASE     = 9'd257;
	localparam logic [16:0] DECODED_MAX  = 17'h1FFFF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_COUNT,
		PH_LITERAL,
		PH_RUNVAL,
		PH_DONE
	} phase_t;

	// One output command: a byte and how many times it is written (1..128)
	typedef struct packed {
		logic [7:0] value;
		logic [7:0] len;
	} cmd_t;

endpackage

/* sv/packbits_bilevel_image_decoder_core.sv */
`timescale 1ns / 1ps
// Top level of the PackBits bi-level image decoder: parser, command queue, expander.
// Depends on pbd_pkg, pbd_front, pbd_cmd_fifo and pbd_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  source   | src_valid / src_stall  | data_byte, image_start
//  result   | res_valid / res_stall  | pixels_first, pixels_second, byte_count, last
//  config   | cfg_we                 | cfg_wdata (output_byte_limit)
//
// One compressed byte is taken per cycle while the four-entry command queue has room.
// A literal byte gives one result; a run of n bytes gives ceil(n/2) results, one per
// cycle from the expander while res_stall is low, so long runs back up the queue and stall the source.
// A result passes through the command queue, the expander's working slot and the output register; res_stall holds it.
// Reset is asynchronous and active low; the limit resets to 51840.
module packbits_bilevel_image_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  data_byte,
	input  logic        image_start,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  pixels_first,
	output logic [7:0]  pixels_second,
	output logic [1:0]  byte_count,
	output logic        last
);
	import pbd_pkg::*;

	logic accept;
	logic q_push, q_pop, q_empty, q_full;
	cmd_t q_in, q_head;

	assign src_stall = q_full;
	assign accept    = src_valid && !src_stall;

	pbd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (data_byte),
		.image_start (image_start),
		.push        (q_push),
		.push_cmd    (q_in)
	);

	pbd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_in),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	pbd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixels_first  (pixels_first),
		.pixels_second (pixels_second),
		.byte_count    (byte_count),
		.last          (last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command popped from an empty queue");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((byte_count == 2'd1 && last && pixels_second == 8'd0) ||
			byte_count == 2'd2))
		else $error("malformed result word");

	a_pair_same: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && byte_count == 2'd2) |-> (pixels_first == pixels_second))
		else $error("two-byte result from different bytes");

endmodule

/* sv/pbd_front.sv */
`timescale 1ns / 1ps
// Front end: header skip, wrapper test, packet parsing and byte limit.
// Depends on pbd_pkg; pushes output commands into pbd_cmd_fifo.
module pbd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          accept,
	input  logic [7:0]    data_byte,
	input  logic          image_start,
	output logic          push,
	output pbd_pkg::cmd_t push_cmd
);
	import pbd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [9:0]  hdr_pos_q, hdr_pos_n;
	logic        wrap_ok_q, wrap_ok_n;
	logic [7:0]  lit_left_q, lit_left_n;
	logic [7:0]  run_len_q, run_len_n;
	logic [16:0] decoded_q, decoded_n;
	logic [15:0] limit_q;

	phase_t      ph;
	logic [9:0]  pos;
	logic        ok;
	logic [16:0] decoded;
	logic [17:0] sum;
	logic [7:0]  add_len;
	logic        emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_pos_q  <= '0;
			wrap_ok_q  <= 1'b1;
			lit_left_q <= '0;
			run_len_q  <= '0;
			decoded_q  <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			hdr_pos_q  <= hdr_pos_n;
			wrap_ok_q  <= wrap_ok_n;
			lit_left_q <= lit_left_n;
			run_len_q  <= run_len_n;
			decoded_q  <= decoded_n;
		end
	end

	always_comb begin
		// a start byte restarts decoding and is itself header byte 0
		ph      = image_start ? PH_HEADER : phase_q;
		pos     = image_start ? 10'd0 : hdr_pos_q;
		ok      = image_start ? 1'b1 : wrap_ok_q;
		decoded = image_start ? 17'd0 : decoded_q;

		phase_n    = ph;
		hdr_pos_n  = pos;
		wrap_ok_n  = ok;
		lit_left_n = lit_left_q;
		run_len_n  = run_len_q;
		emit       = 1'b0;
		add_len    = 8'd1;

		case (ph)
			PH_HEADER: begin
				if (pos == 10'd0 && data_byte != 8'd0)
					wrap_ok_n = 1'b0;
				if (pos == 10'd1 && (data_byte == 8'd0 || data_byte >= WRAP_LEN_LIM))
					wrap_ok_n = 1'b0;
				if ((pos == WRAP_POS_A || pos == WRAP_POS_B) && data_byte != 8'd0)
					wrap_ok_n = 1'b0;
				hdr_pos_n = pos + 10'd1;
				if (hdr_pos_n >= (wrap_ok_n ? WRAP_HDR_LEN : HEADER_LEN))
					phase_n = PH_COUNT;
			end
			PH_COUNT: begin
				if (decoded >= {1'b0, limit_q}) begin
					phase_n = PH_DONE;
				end else if (data_byte < NOOP_COUNT) begin
					lit_left_n = data_byte + 8'd1;
					phase_n    = PH_LITERAL;
				end else if (data_byte > NOOP_COUNT) begin
					run_len_n = 8'(RUN_BASE - {1'b0, data_byte});
					phase_n   = PH_RUNVAL;
				end
			end
			PH_LITERAL: begin
				emit       = 1'b1;
				add_len    = 8'd1;
				lit_left_n = lit_left_q - 8'd1;
				if (lit_left_n == 8'd0)
					phase_n = PH_COUNT;
			end
			PH_RUNVAL: begin
				emit      = 1'b1;
				add_len   = run_len_q;
				run_len_n = 8'd0;
				phase_n   = PH_COUNT;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		sum       = {1'b0, decoded} + {10'd0, add_len};
		decoded_n = decoded;
		if (emit)
			decoded_n = (sum > {1'b0, DECODED_MAX}) ? DECODED_MAX : sum[16:0];

		push           = accept && emit;
		push_cmd.value = data_byte;
		push_cmd.len   = add_len;
	end

endmodule

/* sv/pbd_cmd_fifo.sv */
`timescale 1ns / 1ps
// Short command queue between the parser and the output expander.
// Depends on pbd_pkg for the command type and depth.
module pbd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pbd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output pbd_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import pbd_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= QPTR_W'((32'(wr_q) + 1) % QUEUE_DEPTH);
			if (pop)
				rd_q <= QPTR_W'((32'(rd_q) + 1) % QUEUE_DEPTH);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule

/* sv/pbd_back.sv */
`timescale 1ns / 1ps
// Back end: expands queued commands into results of one or two bytes.
// Depends on pbd_pkg; pops pbd_cmd_fifo and drives the output register.
module pbd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pbd_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [7:0]    pixels_first,
	output logic [7:0]    pixels_second,
	output logic [1:0]    byte_count,
	output logic          last
);
	import pbd_pkg::*;

	logic       active_q;
	logic [7:0] value_q;
	logic [7:0] left_q;
	logic       out_valid_q;
	logic [7:0] first_q, second_q;
	logic [1:0] count_q;
	logic       last_q;

	logic load, emit, pair, done;

	assign load = !out_valid_q || !res_stall;
	assign emit = active_q && load;
	assign pair = (left_q >= 8'd2);
	assign done = (left_q <= 8'd2);
	// refill the working slot when it is empty or as the current command hands out its final result
	assign pop  = !empty && (!active_q || (emit && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				active_q <= 1'b1;
			else if (emit && done)
				active_q <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q <= head.value;
			left_q  <= head.len;
		end else if (emit) begin
			left_q <= left_q - (pair ? 8'd2 : 8'd1);
		end
		if (emit) begin
			first_q  <= value_q;
			second_q <= pair ? value_q : 8'd0;
			count_q  <= pair ? 2'd2 : 2'd1;
			last_q   <= done;
		end
	end

	assign res_valid     = out_valid_q;
	assign pixels_first  = first_q;
	assign pixels_second = second_q;
	assign byte_count    = count_q;
	assign last          = last_q;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the PackBits bi-level image decoder core: builds compressed
// files, predicts the decoded pixel pairs in step with each accepted word, checks them.
// Depends on pbd_pkg and packbits_bilevel_image_decoder_core.
module tb_top;
	import pbd_pkg::*;

	localparam int ITEM_GOAL    = 460;
	localparam int QUIET_CYCLES = 16;
	localparam int DRAIN_CYCLES = 32;
	localparam int TIMEOUT_NS   = 20_000_000;

	typedef enum int {WK_BYTE, WK_LIMIT} word_kind_t;
	typedef enum int {
		HV_WRAPPED, HV_LEAD_NONZERO, HV_LEN_ZERO, HV_LEN_HIGH,
		HV_POS_A_SET, HV_POS_B_SET, HV_RANDOM
	} hdr_variant_t;
	typedef enum int {ST_NONE, ST_ALTERNATE, ST_RANDOM, ST_BURSTS} stall_mode_t;

	typedef struct {
		word_kind_t  kind;
		logic [7:0]  data;
		logic        first;
		logic [15:0] limit;
	} src_word_t;

	typedef struct {
		logic [7:0] px_first;
		logic [7:0] px_second;
		logic [1:0] n_bytes;
		logic       is_last;
	} pixel_pair_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        src_valid = 1'b0;
	logic        src_stall;
	logic [7:0]  data_byte = '0;
	logic        image_start = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  pixels_first;
	logic [7:0]  pixels_second;
	logic [1:0]  byte_count;
	logic        last;

	src_word_t   compressed_stream[$];
	pixel_pair_t pixel_pairs_due[$];
	int          errors = 0;

	// decoder state as predicted
	phase_t      dec_phase;
	logic [9:0]  hdr_pos;
	logic        wrap_ok;
	logic [7:0]  lit_left;
	logic [7:0]  run_len;
	logic [16:0] decoded;
	logic [15:0] byte_limit;

	// stimulus bookkeeping
	int gen_decoded;
	int gen_limit = LIMIT_RESET;
	int counted = 0;

	packbits_bilevel_image_decoder_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.src_valid     (src_valid),
		.src_stall     (src_stall),
		.data_byte     (data_byte),
		.image_start   (image_start),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.pixels_first  (pixels_first),
		.pixels_second (pixels_second),
		.byte_count    (byte_count),
		.last          (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic restart_decode();
		dec_phase = PH_HEADER;
		hdr_pos   = '0;
		wrap_ok   = 1'b1;
		lit_left  = '0;
		run_len   = '0;
		decoded   = '0;
	endtask

	task automatic add_decoded(input int n);
		int sum;
		sum = decoded + n;
		decoded = (sum > DECODED_MAX) ? DECODED_MAX : 17'(sum);
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic first);
		logic [9:0]  hdr_end;
		logic [7:0]  left;
		logic [1:0]  c;
		pixel_pair_t r;
		if (first)
			restart_decode();
		case (dec_phase)
		PH_HEADER: begin
			if (hdr_pos == 0 && b != 0)
				wrap_ok = 1'b0;
			if (hdr_pos == 1 && (b == 0 || b >= WRAP_LEN_LIM))
				wrap_ok = 1'b0;
			if ((hdr_pos == WRAP_POS_A || hdr_pos == WRAP_POS_B) && b != 0)
				wrap_ok = 1'b0;
			hdr_pos = hdr_pos + 10'd1;
			hdr_end = wrap_ok ? WRAP_HDR_LEN : HEADER_LEN;
			if (hdr_pos >= hdr_end)
				dec_phase = PH_COUNT;
		end
		PH_COUNT: begin
			if (decoded >= {1'b0, byte_limit}) begin
				dec_phase = PH_DONE;
			end else if (b < NOOP_COUNT) begin
				lit_left = b + 8'd1;
				dec_phase = PH_LITERAL;
			end else if (b > NOOP_COUNT) begin
				run_len = 8'(RUN_BASE - {1'b0, b});
				dec_phase = PH_RUNVAL;
			end
		end
		PH_LITERAL: begin
			r = '{b, 8'd0, 2'd1, 1'b1};
			pixel_pairs_due.push_back(r);
			add_decoded(1);
			if (lit_left > 0)
				lit_left--;
			if (lit_left == 0)
				dec_phase = PH_COUNT;
		end
		PH_RUNVAL: begin
			left = run_len;
			while (left > 0) begin
				c = (left >= 2) ? 2'd2 : 2'd1;
				left = left - c;
				r = '{b, (c == 2) ? b : 8'd0, c, left == 0};
				pixel_pairs_due.push_back(r);
			end
			add_decoded(run_len);
			run_len = '0;
			dec_phase = PH_COUNT;
		end
		default: dec_phase = PH_DONE;
		endcase
	endtask

	// sender: bursts of words with random gaps, limit writes only when the block is idle
	always @(posedge clk or negedge arst_n) begin : drive
		src_word_t   w;
		logic        nv;
		logic        nstart;
		logic        nwe;
		logic [7:0]  nbyte;
		logic [15:0] nwdata;
		int          burst_left;
		int          gap_left;
		int          quiet;
		if (!arst_n) begin
			src_valid   <= 1'b0;
			data_byte   <= '0;
			image_start <= 1'b0;
			cfg_we      <= 1'b0;
			cfg_wdata   <= '0;
			burst_left  = 0;
			gap_left    = 0;
			quiet       = 0;
			byte_limit  = LIMIT_RESET;
			restart_decode();
		end else begin
			nv     = src_valid;
			nbyte  = data_byte;
			nstart = image_start;
			nwe    = 1'b0;
			nwdata = cfg_wdata;
			if (src_valid && !src_stall) begin
				decode_byte(data_byte, image_start);
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (compressed_stream.size() > 0 &&
						compressed_stream[0].kind == WK_LIMIT) begin
					// hold the write until all results are out and the block has settled
					if (pixel_pairs_due.size() == 0 && !src_valid)
						quiet++;
					else
						quiet = 0;
					if (quiet >= QUIET_CYCLES) begin
						w = compressed_stream.pop_front();
						nwe = 1'b1;
						nwdata = w.limit;
						byte_limit = w.limit;
						quiet = 0;
					end
				end else if (compressed_stream.size() > 0) begin
					w = compressed_stream.pop_front();
					nv = 1'b1;
					nbyte = w.data;
					nstart = w.first;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			src_valid   <= nv;
			data_byte   <= nbyte;
			image_start <= nstart;
			cfg_we      <= nwe;
			cfg_wdata   <= nwdata;
		end
	end

	// receiver: check each word against the oldest prediction, stall on its own pattern
	always @(posedge clk or negedge arst_n) begin : receive
		pixel_pair_t want;
		stall_mode_t stall_mode;
		logic [15:0] stall_cyc;
		int          hold_left;
		logic        nst;
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_mode = ST_NONE;
			stall_cyc  = '0;
			hold_left  = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pixel_pairs_due.size() == 0) begin
					$error("result word with no expected pixel pair waiting");
					errors++;
				end else begin
					want = pixel_pairs_due.pop_front();
					if (pixels_first !== want.px_first) begin
						$error("pixels_first: expected %0h, got %0h", want.px_first, pixels_first);
						errors++;
					end
					if (pixels_second !== want.px_second) begin
						$error("pixels_second: expected %0h, got %0h",
							want.px_second, pixels_second);
						errors++;
					end
					if (byte_count !== want.n_bytes) begin
						$error("byte_count: expected %0d, got %0d", want.n_bytes, byte_count);
						errors++;
					end
					if (last !== want.is_last) begin
						$error("last: expected %0b, got %0b", want.is_last, last);
						errors++;
					end
				end
			end
			stall_cyc = stall_cyc + 16'd1;
			if (stall_cyc[7:0] == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
			ST_NONE:      nst = 1'b0;
			ST_ALTERNATE: nst = stall_cyc[0];
			ST_RANDOM:    nst = ($urandom_range(0, 2) == 0);
			default: begin
				if (hold_left > 0) begin
					hold_left--;
					nst = 1'b1;
				end else if ($urandom_range(0, 9) == 0) begin
					hold_left = $urandom_range(1, 15);
					nst = 1'b1;
				end else begin
					nst = 1'b0;
				end
			end
			endcase
			res_stall <= nst;
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic first);
		src_word_t w;
		w = '{WK_BYTE, b, first, 16'd0};
		compressed_stream.push_back(w);
	endtask

	task automatic put_limit(input logic [15:0] v);
		src_word_t w;
		w = '{WK_LIMIT, 8'd0, 1'b0, v};
		compressed_stream.push_back(w);
		gen_limit = v;
	endtask

	// one file header; cut > 0 truncates it so the next file restarts mid-header
	task automatic put_header(input hdr_variant_t variant, input int cut);
		logic [7:0] blk [0:127];
		logic       ok;
		int         hdr_len;
		foreach (blk[i])
			blk[i] = 8'($urandom_range(0, 255));
		if (variant != HV_RANDOM) begin
			blk[0]  = 8'd0;
			case ($urandom_range(0, 2))
			0:       blk[1] = 8'd1;
			1:       blk[1] = 8'd63;
			default: blk[1] = 8'($urandom_range(1, 63));
			endcase
			blk[74] = 8'd0;
			blk[82] = 8'd0;
		end
		case (variant)
		HV_LEAD_NONZERO: blk[0] = 8'($urandom_range(1, 255));
		HV_LEN_ZERO:     blk[1] = 8'd0;
		HV_LEN_HIGH:     blk[1] = $urandom_range(0, 1) ? 8'd64 : 8'($urandom_range(64, 255));
		HV_POS_A_SET:    blk[74] = 8'($urandom_range(1, 255));
		HV_POS_B_SET:    blk[82] = 8'($urandom_range(1, 255));
		default: ;
		endcase
		ok = blk[0] == 0 && blk[1] != 0 && blk[1] < WRAP_LEN_LIM && blk[74] == 0 && blk[82] == 0;
		hdr_len = ok ? WRAP_HDR_LEN : HEADER_LEN;
		if (cut > 0 && cut < hdr_len)
			hdr_len = cut;
		for (int i = 0; i < hdr_len; i++)
			put_byte((i < 128) ? blk[i] : 8'($urandom_range(0, 255)), i == 0);
		gen_decoded = 0;
	endtask

	// literal packet; keep < n+1 leaves it unfinished
	task automatic put_literal(input int n, input int keep);
		put_byte(8'(n), 1'b0);
		for (int i = 0; i < keep; i++)
			put_byte(8'($urandom_range(0, 255)), 1'b0);
		gen_decoded += keep;
		counted += 1 + keep;
	endtask

	task automatic put_run(input logic [7:0] cnt, input logic [7:0] v);
		put_byte(cnt, 1'b0);
		put_byte(v, 1'b0);
		gen_decoded += 257 - cnt;
		counted += 2;
	endtask

	initial begin : run_stimulus
		int          file_no;
		int          budget;
		int          used;
		int          pick;
		int          n;
		int          guard;
		logic        done;
		logic [7:0]  cnt;
		logic [7:0]  v;
		hdr_variant_t variant;

		// wrapped file at the reset limit: every packet kind, odd run, longest run
		put_header(HV_WRAPPED, 0);
		put_byte(8'd0, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'd1, 1'b0);
		put_byte(8'hFF, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(NOOP_COUNT, 1'b0);
		put_run(8'd255, 8'hFF);
		put_run(8'd254, 8'h00);
		put_run(8'd129, 8'h5A);
		// literal cut short by the next file
		put_byte(8'd3, 1'b0);
		put_byte(8'h81, 1'b0);
		put_byte(8'h7E, 1'b0);

		// zero limit: the first count byte ends the file, the rest is dropped
		put_limit(16'd0);
		put_header(HV_LEAD_NONZERO, 0);
		put_byte(8'd2, 1'b0);
		put_byte(8'd255, 1'b0);
		put_byte(8'h33, 1'b0);

		// packet in flight completes past the limit
		put_limit(16'd3);
		put_header(HV_LEN_ZERO, 0);
		put_literal(4, 5);
		put_byte(8'd255, 1'b0);
		put_byte(8'h11, 1'b0);

		put_header(HV_LEN_HIGH, 40);
		put_limit(16'hFFFF);

		file_no = 0;
		while (counted < ITEM_GOAL) begin
			if (file_no > 0 && $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 5))
				0:       put_limit(16'd0);
				1:       put_limit(16'd1);
				2:       put_limit(16'($urandom_range(2, 40)));
				3:       put_limit(16'($urandom_range(40, 400)));
				4:       put_limit(16'hFFFF);
				default: put_limit(LIMIT_RESET);
				endcase
			end
			variant = (file_no < 7) ? hdr_variant_t'(file_no)
				: hdr_variant_t'($urandom_range(0, 6));
			if ($urandom_range(0, 9) == 0)
				put_header(hdr_variant_t'($urandom_range(0, 6)), $urandom_range(1, 600));
			put_header(variant, 0);
			budget = $urandom_range(20, 90);
			used = 0;
			done = 1'b0;
			while (used < budget && !done) begin
				if (gen_decoded >= gen_limit) begin
					put_byte(8'($urandom_range(0, 255)), 1'b0);
					counted++;
					repeat ($urandom_range(0, 4))
						put_byte(8'($urandom_range(0, 255)), 1'b0);
					done = 1'b1;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 45) begin
						n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 127)
							: $urandom_range(0, 7);
						put_literal(n, n + 1);
						used += n + 2;
					end else if (pick < 85) begin
						cnt = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(129, 248))
							: 8'($urandom_range(249, 255));
						if ($urandom_range(0, 3) == 0)
							v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						else
							v = 8'($urandom_range(0, 255));
						put_run(cnt, v);
						used += 2;
					end else if (pick < 92) begin
						put_byte(NOOP_COUNT, 1'b0);
						counted++;
						used++;
					end else begin
						// abandon the packet: the next file restarts the decoder
						if ($urandom_range(0, 1)) begin
							n = $urandom_range(2, 20);
							put_literal(n, $urandom_range(0, n));
						end else begin
							put_byte(8'($urandom_range(129, 255)), 1'b0);
							counted++;
						end
						done = 1'b1;
					end
				end
			end
			file_no++;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (compressed_stream.size() != 0 || src_valid)
			@(posedge clk);
		guard = 0;
		while (pixel_pairs_due.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pixel_pairs_due.size() != 0) begin
			$error("%0d expected pixel pairs never arrived", pixel_pairs_due.size());
			errors++;
		end
		if (errors == 0)
			$display("packbits_bilevel_image_decoder_core verification clean");
		else
			$display("packbits_bilevel_image_decoder_core verification failed");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("packbits_bilevel_image_decoder_core verification failed");
		$finish;
	end

endmodule
